### rtl/core/tgbc_pkg.sv
package tgbc_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam int FRAC_W = 8;
	localparam int POS_W = 16;
	localparam int MASK_W = 32;
	localparam int CFG_W = 7;
	localparam int IDX_W = 1;
	localparam int SUM_W = POS_W + FRAC_W + 3;

	localparam int IN_DATA_W = 136;
	localparam int IN_USER_W = 1;
	localparam int OUT_DATA_W = 8;
	localparam int CAUSE_W = 2;

	localparam logic [IDX_W-1:0] REG_GRID_ROWS = 1'b0;
	localparam logic [IDX_W-1:0] REG_GRID_COLS = 1'b1;

	localparam logic OP_QUERY = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [CAUSE_W-1:0] CAUSE_NONE = 2'd0;
	localparam logic [CAUSE_W-1:0] CAUSE_BOUNDS = 2'd1;
	localparam logic [CAUSE_W-1:0] CAUSE_BLOCKED = 2'd2;

	function automatic logic [ADDR_W-1:0] tile_addr(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
	endfunction

endpackage

### rtl/core/tile_grid_box_collision_check_unit.sv
// Tile grid collision checker. Items arrive on the s_axis stream. A write item (tuser set)
// loads one tile mask if its tile lies within the mask memory. A query works out its box
// centre and its left, right, bottom and top edges through one shared adder and then checks
// the map bounds. It then reads the tile memory once per covered tile with one read port and
// loads the result word once the last read is checked. A blocked tile ends the scan early,
// and a query outside the map or in the sky layer answers after the bounds check with no scan.
// A write or a query flagged no-collision loads the output register at the accepting edge when
// it is free, and the next word can follow in the next cycle. A result word that waits on
// m_axis does not close the input by itself, but the next item accepted behind it holds the
// input closed until its own result can be loaded. Each item gives one word on m_axis.
// After reset the block clears the 4096-entry mask memory, one entry per cycle, and holds
// s_axis_tready low until the clear is done; configuration writes are taken anyway.
module tile_grid_box_collision_check_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// tile_x, tile_y, offset_x, offset_y, half_width, box_height, context_mask,
	// never_collide, sky_layer, zero fill
	input  logic [tgbc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// operation
	input  logic [tgbc_pkg::IN_USER_W-1:0]       s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// collides, cause, zero fill
	output logic [tgbc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	input  logic                                 cfg_we,
	input  logic [tgbc_pkg::IDX_W-1:0]           cfg_index,
	input  logic [tgbc_pkg::CFG_W-1:0]           cfg_data
);
	import tgbc_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_CALC  = 3'd2;
	localparam logic [2:0] ST_BOUND = 3'd3;
	localparam logic [2:0] ST_SCAN  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	localparam logic [2:0] STEP_CX     = 3'd0;
	localparam logic [2:0] STEP_LEFT   = 3'd1;
	localparam logic [2:0] STEP_RIGHT  = 3'd2;
	localparam logic [2:0] STEP_BOTTOM = 3'd3;
	localparam logic [2:0] STEP_TOP    = 3'd4;

	logic [2:0] state_q;
	logic [2:0] step_q;
	logic [ADDR_W-1:0] clr_q;
	logic [CFG_W-1:0] grid_rows_q, grid_cols_q;

	logic signed [POS_W-1:0] tx_q, ty_q, ox_q, oy_q;
	logic [POS_W-1:0] hw_q, bh_q;
	logic [MASK_W-1:0] ctx_q;
	logic sky_q;
	logic signed [SUM_W-1:0] cx_q, left_q, right_q, bot_q, top_q;

	logic [ROW_W-1:0] r_q, r1_q;
	logic [COL_W-1:0] c_q, c0_q, c1_q;
	logic issue_q, pend_q, last_q;

	logic res_hit_q;
	logic [CAUSE_W-1:0] res_cause_q;
	logic out_valid_q, out_hit_q;
	logic [CAUSE_W-1:0] out_cause_q;

	logic [MASK_W-1:0] mem [DEPTH];
	logic [MASK_W-1:0] rdata_q;

	logic in_op, in_nocoll, in_sky;
	logic signed [POS_W-1:0] in_tx, in_ty, in_ox, in_oy;
	logic [POS_W-1:0] in_hw, in_bh;
	logic [MASK_W-1:0] in_ctx;

	assign in_op     = s_axis_tuser[0];
	assign in_tx     = s_axis_tdata[15:0];
	assign in_ty     = s_axis_tdata[31:16];
	assign in_ox     = s_axis_tdata[47:32];
	assign in_oy     = s_axis_tdata[63:48];
	assign in_hw     = s_axis_tdata[79:64];
	assign in_bh     = s_axis_tdata[95:80];
	assign in_ctx    = s_axis_tdata[127:96];
	assign in_nocoll = s_axis_tdata[128];
	assign in_sky    = s_axis_tdata[129];

	logic accept, out_free, out_load, wr_in_range, mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [MASK_W-1:0] mem_wd;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign out_load = (accept && (in_op == OP_WRITE || in_nocoll) && out_free)
		|| (state_q == ST_DONE && out_free);
	assign wr_in_range = !in_tx[POS_W-1] && ({1'b0, in_tx[POS_W-2:0]} < POS_W'(MAX_COLS))
		&& !in_ty[POS_W-1] && ({1'b0, in_ty[POS_W-2:0]} < POS_W'(MAX_ROWS));

	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_q;
		mem_wd = '0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (accept && in_op == OP_WRITE && wr_in_range) begin
			mem_we = 1'b1;
			mem_wa = tile_addr(in_ty[ROW_W-1:0], in_tx[COL_W-1:0]);
			mem_wd = in_ctx;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[tile_addr(r_q, c_q)];
	end

	logic signed [SUM_W-1:0] add_a, add_b, add_sum;
	logic add_sub;

	always_comb begin
		add_a = cx_q;
		add_b = '0;
		add_sub = 1'b0;
		unique case (step_q)
			STEP_CX: begin
				add_a = {{(SUM_W-POS_W-FRAC_W){tx_q[POS_W-1]}}, tx_q, FRAC_W'(0)};
				add_b = SUM_W'(ox_q);
			end
			STEP_LEFT: begin
				add_b = $signed(SUM_W'(hw_q));
				add_sub = 1'b1;
			end
			STEP_RIGHT: begin
				add_b = $signed(SUM_W'(hw_q));
			end
			STEP_BOTTOM: begin
				add_a = {{(SUM_W-POS_W-FRAC_W){ty_q[POS_W-1]}}, ty_q, FRAC_W'(0)};
				add_b = SUM_W'(oy_q);
			end
			STEP_TOP: begin
				add_a = bot_q;
				add_b = $signed(SUM_W'(bh_q));
				add_sub = 1'b1;
			end
			default: begin
				add_a = cx_q;
			end
		endcase
		add_sum = add_a + (add_sub ? ~add_b : add_b) + SUM_W'(add_sub);
	end

	logic [CFG_W-1:0] rows_eff, cols_eff;
	logic signed [SUM_W-1:0] rows_lim, cols_lim;
	logic out_of_map;

	assign rows_eff = (int'(grid_rows_q) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : grid_rows_q;
	assign cols_eff = (int'(grid_cols_q) > MAX_COLS) ? CFG_W'(MAX_COLS) : grid_cols_q;
	assign rows_lim = $signed(SUM_W'({rows_eff, FRAC_W'(0)}));
	assign cols_lim = $signed(SUM_W'({cols_eff, FRAC_W'(0)}));
	assign out_of_map = left_q[SUM_W-1] || top_q[SUM_W-1]
		|| (right_q >= cols_lim) || (bot_q >= rows_lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= CFG_W'(64);
			grid_cols_q <= CFG_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_ROWS: grid_rows_q <= cfg_data;
				REG_GRID_COLS: grid_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tx_q  <= in_tx;
			ty_q  <= in_ty;
			ox_q  <= in_ox;
			oy_q  <= in_oy;
			hw_q  <= in_hw;
			bh_q  <= in_bh;
			ctx_q <= in_ctx;
			sky_q <= in_sky;
		end
		if (state_q == ST_CALC) begin
			unique case (step_q)
				STEP_CX:     cx_q    <= add_sum;
				STEP_LEFT:   left_q  <= add_sum;
				STEP_RIGHT:  right_q <= add_sum;
				STEP_BOTTOM: bot_q   <= add_sum;
				STEP_TOP:    top_q   <= add_sum;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			step_q      <= STEP_CX;
			clr_q       <= '0;
			r_q         <= '0;
			r1_q        <= '0;
			c_q         <= '0;
			c0_q        <= '0;
			c1_q        <= '0;
			issue_q     <= 1'b0;
			pend_q      <= 1'b0;
			last_q      <= 1'b0;
			res_hit_q   <= 1'b0;
			res_cause_q <= CAUSE_NONE;
			out_valid_q <= 1'b0;
			out_hit_q   <= 1'b0;
			out_cause_q <= CAUSE_NONE;
		end else begin
			if (m_axis_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (in_op == OP_WRITE || in_nocoll) begin
							if (out_free) begin
								out_valid_q <= 1'b1;
								out_hit_q   <= 1'b0;
								out_cause_q <= CAUSE_NONE;
							end else begin
								res_hit_q   <= 1'b0;
								res_cause_q <= CAUSE_NONE;
								state_q     <= ST_DONE;
							end
						end else begin
							step_q  <= STEP_CX;
							state_q <= ST_CALC;
						end
					end
				end
				ST_CALC: begin
					step_q <= step_q + 3'd1;
					if (step_q == STEP_TOP) begin
						state_q <= ST_BOUND;
					end
				end
				ST_BOUND: begin
					if (out_of_map) begin
						res_hit_q   <= 1'b1;
						res_cause_q <= CAUSE_BOUNDS;
						state_q     <= ST_DONE;
					end else if (sky_q) begin
						res_hit_q   <= 1'b0;
						res_cause_q <= CAUSE_NONE;
						state_q     <= ST_DONE;
					end else begin
						r_q     <= top_q[FRAC_W +: ROW_W];
						r1_q    <= bot_q[FRAC_W +: ROW_W];
						c_q     <= left_q[FRAC_W +: COL_W];
						c0_q    <= left_q[FRAC_W +: COL_W];
						c1_q    <= right_q[FRAC_W +: COL_W];
						issue_q <= 1'b1;
						pend_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					pend_q <= issue_q;
					if (issue_q) begin
						last_q <= (r_q == r1_q) && (c_q == c1_q);
						if ((r_q == r1_q) && (c_q == c1_q)) begin
							issue_q <= 1'b0;
						end else if (c_q == c1_q) begin
							c_q <= c0_q;
							r_q <= r_q + ROW_W'(1);
						end else begin
							c_q <= c_q + COL_W'(1);
						end
					end
					if (pend_q) begin
						if ((rdata_q & ctx_q) != '0) begin
							res_hit_q   <= 1'b1;
							res_cause_q <= CAUSE_BLOCKED;
							state_q     <= ST_DONE;
						end else if (last_q) begin
							res_hit_q   <= 1'b0;
							res_cause_q <= CAUSE_NONE;
							state_q     <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_hit_q   <= res_hit_q;
						out_cause_q <= res_cause_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = OUT_DATA_W'({out_cause_q, out_hit_q});

endmodule

### rtl/core/tgbc_checker.sv
module tgbc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [tgbc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input logic [tgbc_pkg::IN_USER_W-1:0]  s_axis_tuser,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [tgbc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import tgbc_pkg::*;

	// A waiting result word must not change until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// A collision always carries a cause, and a clear answer carries none.
	a_hit_cause: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] != CAUSE_NONE))
			&& (m_axis_tdata[2:1] == CAUSE_NONE || m_axis_tdata[2:1] == CAUSE_BOUNDS
			|| m_axis_tdata[2:1] == CAUSE_BLOCKED))
		else $error("collides and cause disagree");

	// The memory clear keeps the input closed right after reset.
	a_clear_busy: assert property (@(posedge clk)
		$rose(arst_n) |-> !s_axis_tready)
		else $error("input opened during memory clear");

	// A query that can collide runs the box arithmetic, so the input closes.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == OP_QUERY
			&& !s_axis_tdata[128] |=> !s_axis_tready)
		else $error("input open while a query is in progress");

endmodule

bind tile_grid_box_collision_check_unit tgbc_checker u_tgbc_checker (.*);
